// ===== rtl/assert_macros.svh =====
// assert_macros.svh - assertion macros for the LED matrix scanout checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on i_clk, off while in reset
`define LMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// sig keeps its value in the cycle after cond
`define LMD_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/lmd_pkg.sv =====
// lmd_pkg.sv - shared types and codes of the LED matrix double-buffer scanout.
// No dependencies.
`default_nettype none

package lmd_pkg;

    // command modes
    localparam logic [2:0] MODE_SET      = 3'd0;
    localparam logic [2:0] MODE_FILL_ROW = 3'd1;
    localparam logic [2:0] MODE_FILL_COL = 3'd2;
    localparam logic [2:0] MODE_CLEAR    = 3'd3;
    localparam logic [2:0] MODE_SCAN     = 3'd4;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [5:0] ROWS_RESET = 6'd32;
    localparam logic [6:0] COLS_RESET = 7'd32;
    localparam int         ROW_CAP    = 32;

    // panel size after saturation
    typedef struct packed {
        logic [5:0] rows;
        logic [6:0] cols;
    } t_cfg;

    // one stored pixel: channel-nonzero flags
    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } t_pix;

    // upper and lower pixel read together
    typedef struct packed {
        t_pix up;
        t_pix lo;
    } t_pair;

    // one scanout result
    typedef struct packed {
        logic [3:0] line;
        t_pix       up;
        t_pix       lo;
        logic       latch;
    } t_beat;

endpackage

`default_nettype wire

// ===== rtl/lmd_in_if.sv =====
// lmd_in_if.sv - command channel of the LED matrix scanout: valid/ready plus
// draw and scan command fields. No dependencies.
`default_nettype none

interface lmd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [5:0]  column;
    logic [4:0]  row;
    logic [23:0] color;

    modport source (output valid, output mode, output column, output row, output color,
                    input ready);
    modport sink   (input valid, input mode, input column, input row, input color,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lmd_out_if.sv =====
// lmd_out_if.sv - scanout result channel: valid/ready plus per-column pixel bits.
// No dependencies.
`default_nettype none

interface lmd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] line_address;
    logic       upper_red;
    logic       upper_green;
    logic       upper_blue;
    logic       lower_red;
    logic       lower_green;
    logic       lower_blue;
    logic       latch_now;

    modport source (output valid, output line_address, output upper_red, output upper_green,
                    output upper_blue, output lower_red, output lower_green,
                    output lower_blue, output latch_now, input ready);
    modport sink   (input valid, input line_address, input upper_red, input upper_green,
                    input upper_blue, input lower_red, input lower_green,
                    input lower_blue, input latch_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/lmd_ram.sv =====
// lmd_ram.sv - frame store: one write port, two registered read ports.
// Depends on lmd_pkg for the pixel type.
`default_nettype none

module lmd_ram
    import lmd_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_pix          i_wdata,
    input  wire logic [AW-1:0] i_raddr_up,
    input  wire logic [AW-1:0] i_raddr_lo,
    output t_pair              o_rdata
);

    t_pix mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata.up <= mem[i_raddr_up];
        o_rdata.lo <= mem[i_raddr_lo];
    end

endmodule

`default_nettype wire

// ===== rtl/lmd_seq.sv =====
// lmd_seq.sv - command sequencer: write walks for draw/clear, buffer swap and
// column-by-column scanout into the output register.
// Depends on lmd_pkg, lmd_in_if, lmd_out_if.
`default_nettype none

module lmd_seq
    import lmd_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    lmd_in_if.sink     i_cmd,
    lmd_out_if.source  o_pix,
    output logic       o_we_a,
    output logic       o_we_b,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] o_waddr,
    output t_pix       o_wdata,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] o_raddr_up,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] o_raddr_lo,
    input  wire t_pair i_rd_a,
    input  wire t_pair i_rd_b
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW    = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]    r_state;
    logic          r_front_b;
    logic          r_pending;
    logic [3:0]    r_scan_line;
    logic [3:0]    r_line;
    logic [AW-1:0] r_wr_addr;
    logic [LW-1:0] r_wr_left;
    logic          r_wr_col;
    logic          r_wr_both;
    t_pix          r_wr_data;
    logic [AW-1:0] r_up_base;
    logic [AW-1:0] r_lo_base;
    logic [CW-1:0] r_dcol;
    logic          r_dvld;
    logic          r_ovld;
    t_beat         r_out;

    logic [4:0]    half;
    logic [3:0]    line_sel;
    logic          row_ok;
    logic          col_ok;
    logic          accept;
    logic          load;
    logic          last;
    logic [CW-1:0] rd_col;
    logic          we;
    t_pix          cmd_pix;
    t_pair         rd_front;
    logic          n_ovld;

    assign half     = i_cfg.rows[5:1];
    // a line left over from a larger panel restarts at line 0
    assign line_sel = ({1'b0, r_scan_line} >= half) ? 4'd0 : r_scan_line;
    assign row_ok   = {1'b0, i_cmd.row} < i_cfg.rows;
    assign col_ok   = {1'b0, i_cmd.column} < i_cfg.cols;
    assign accept   = i_cmd.valid && (r_state == ST_IDLE);
    assign i_cmd.ready = (r_state == ST_IDLE);

    assign cmd_pix.red   = |i_cmd.color[23:16];
    assign cmd_pix.green = |i_cmd.color[15:8];
    assign cmd_pix.blue  = |i_cmd.color[7:0];

    // write walk; during the reset clear both stores are written
    assign we      = (r_state == ST_FILL);
    assign o_we_a  = we && (r_wr_both || r_front_b);
    assign o_we_b  = we && (r_wr_both || !r_front_b);
    assign o_waddr = r_wr_addr;
    assign o_wdata = r_wr_data;

    // Read data is re-fetched from the same column until the output register
    // takes it; the front store does not change during a scan.
    assign load   = r_dvld && (!r_ovld || o_pix.ready);
    assign last   = (7'(r_dcol) + 7'd1) == i_cfg.cols;
    assign rd_col = !r_dvld ? '0 : (load ? CW'(r_dcol + 1'b1) : r_dcol);
    assign o_raddr_up = r_up_base + AW'(rd_col);
    assign o_raddr_lo = r_lo_base + AW'(rd_col);
    assign rd_front   = r_front_b ? i_rd_b : i_rd_a;

    assign n_ovld = load ? 1'b1 : (o_pix.ready ? 1'b0 : r_ovld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_front_b   <= 1'b0;
            r_pending   <= 1'b1;
            r_scan_line <= 4'd0;
            r_wr_addr   <= '0;
            r_wr_left   <= LW'(DEPTH);
            r_wr_col    <= 1'b0;
            r_wr_both   <= 1'b1;
            r_wr_data   <= '0;
            r_dvld      <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_ovld <= n_ovld;
            if (load) begin
                r_out.line  <= r_line;
                r_out.up    <= rd_front.up;
                r_out.lo    <= rd_front.lo;
                r_out.latch <= last;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_cmd.mode)
                            MODE_SET: begin
                                if (row_ok && col_ok) begin
                                    r_wr_addr <= AW'(32'(i_cmd.row) * MAX_COLS
                                                     + 32'(i_cmd.column));
                                    r_wr_left <= LW'(1);
                                    r_wr_col  <= 1'b0;
                                    r_wr_data <= cmd_pix;
                                    r_pending <= 1'b1;
                                    r_state   <= ST_FILL;
                                end
                            end
                            MODE_FILL_ROW: begin
                                if (row_ok) begin
                                    r_wr_addr <= AW'(32'(i_cmd.row) * MAX_COLS);
                                    r_wr_left <= LW'(i_cfg.cols);
                                    r_wr_col  <= 1'b0;
                                    r_wr_data <= cmd_pix;
                                    r_pending <= 1'b1;
                                    r_state   <= ST_FILL;
                                end
                            end
                            MODE_FILL_COL: begin
                                if (col_ok) begin
                                    r_wr_addr <= AW'(i_cmd.column);
                                    r_wr_left <= LW'(i_cfg.rows);
                                    r_wr_col  <= 1'b1;
                                    r_wr_data <= cmd_pix;
                                    r_pending <= 1'b1;
                                    r_state   <= ST_FILL;
                                end
                            end
                            MODE_CLEAR: begin
                                r_wr_addr <= '0;
                                r_wr_left <= LW'(DEPTH);
                                r_wr_col  <= 1'b0;
                                r_wr_data <= '0;
                                r_pending <= 1'b1;
                                r_state   <= ST_FILL;
                            end
                            MODE_SCAN: begin
                                if (line_sel == 4'd0 && r_pending) begin
                                    r_front_b <= !r_front_b;
                                    r_pending <= 1'b0;
                                end
                                r_line      <= line_sel;
                                r_up_base   <= AW'(32'(line_sel) * MAX_COLS);
                                r_lo_base   <= AW'((32'(line_sel) + 32'(half)) * MAX_COLS);
                                r_scan_line <= ({1'b0, line_sel} + 5'd1 >= half)
                                               ? 4'd0 : line_sel + 4'd1;
                                r_dvld      <= 1'b0;
                                r_state     <= ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    r_wr_addr <= r_wr_addr + (r_wr_col ? AW'(MAX_COLS) : AW'(1));
                    r_wr_left <= r_wr_left - LW'(1);
                    if (r_wr_left == LW'(1)) begin
                        r_wr_both <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (!r_dvld) begin
                        r_dvld <= 1'b1;
                        r_dcol <= '0;
                    end else if (load) begin
                        if (last) begin
                            r_dvld  <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_dcol <= CW'(r_dcol + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_pix.valid        = r_ovld;
    assign o_pix.line_address = r_out.line;
    assign o_pix.upper_red    = r_out.up.red;
    assign o_pix.upper_green  = r_out.up.green;
    assign o_pix.upper_blue   = r_out.up.blue;
    assign o_pix.lower_red    = r_out.lo.red;
    assign o_pix.lower_green  = r_out.lo.green;
    assign o_pix.lower_blue   = r_out.lo.blue;
    assign o_pix.latch_now    = r_out.latch;

endmodule

`default_nettype wire

// ===== rtl/led_matrix_double_buffer_scanout_unit.sv =====
// Double-buffered framebuffer and line-pair scanout for a row-pair scanned RGB
// LED panel. Commands on i_cmd draw into the back store (set pixel, fill row,
// fill column, clear) or scan the next line pair out of the front store; a
// scan at line 0 swaps the stores first if anything was drawn. Each scan gives
// one transaction per column on o_pix, the last with latch_now set. Set pixel
// writes one location, fill row panel_cols locations, fill column panel_rows
// locations and clear MAX_ROWS*MAX_COLS locations, one store write per cycle.
// A scan delivers one column per cycle while o_pix is not stalled, reading
// upper and lower pixel on the two registered read ports of the front store.
// After reset both stores are cleared in a pass over all MAX_ROWS*MAX_COLS
// locations during which no command is taken; configuration writes are taken
// at any time and must only be issued while the block is idle.
//
// Depends on lmd_pkg, lmd_in_if, lmd_out_if, lmd_ram, lmd_seq.
`default_nettype none

module led_matrix_double_buffer_scanout_unit
    import lmd_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    lmd_in_if.sink          i_cmd,
    lmd_out_if.source       o_pix,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RowLim = (MAX_ROWS < ROW_CAP) ? MAX_ROWS : ROW_CAP;

    logic [5:0]    r_panel_rows;
    logic [6:0]    r_panel_cols;
    t_cfg          cfg;
    logic          we_a;
    logic          we_b;
    logic [AW-1:0] waddr;
    t_pix          wdata;
    logic [AW-1:0] raddr_up;
    logic [AW-1:0] raddr_lo;
    t_pair         rd_a;
    t_pair         rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_rows <= ROWS_RESET;
            r_panel_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_panel_rows <= i_cfg_data[5:0];
                CFG_COLS: r_panel_cols <= i_cfg_data;
                default:  r_panel_cols <= r_panel_cols;
            endcase
        end
    end

    // saturate the panel size to 2..min(MAX_ROWS, ROW_CAP) rows and 1..MAX_COLS columns
    assign cfg.rows = (r_panel_rows > 6'(RowLim)) ? 6'(RowLim)
                    : ((r_panel_rows < 6'd2) ? 6'd2 : r_panel_rows);
    assign cfg.cols = (r_panel_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS)
                    : ((r_panel_cols < 7'd1) ? 7'd1 : r_panel_cols);

    lmd_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (i_cmd),
        .o_pix      (o_pix),
        .o_we_a     (we_a),
        .o_we_b     (we_b),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr_up (raddr_up),
        .o_raddr_lo (raddr_lo),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b)
    );

    lmd_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .i_clk      (i_clk),
        .i_we       (we_a),
        .i_waddr    (waddr),
        .i_wdata    (wdata),
        .i_raddr_up (raddr_up),
        .i_raddr_lo (raddr_lo),
        .o_rdata    (rd_a)
    );

    lmd_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .i_clk      (i_clk),
        .i_we       (we_b),
        .i_waddr    (waddr),
        .i_wdata    (wdata),
        .i_raddr_up (raddr_up),
        .i_raddr_lo (raddr_lo),
        .o_rdata    (rd_b)
    );

endmodule

`default_nettype wire

// ===== rtl/lmd_checker.sv =====
// lmd_checker.sv - port-level assertions for the LED matrix scanout, bound to
// the top level. Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] i_out_line,
    input wire logic [5:0] i_out_bits,
    input wire logic       i_out_latch
);

    logic [10:0] out_word;
    assign out_word = {i_out_line, i_out_bits, i_out_latch};

    `LMD_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")
    `LMD_ASSERT_HOLD(a_out_stable, i_out_valid && !i_out_ready, out_word, "result changed while stalled")
    // mid-line columns mean the scan is still running, so no command is taken
    `LMD_ASSERT(a_busy_mid_line, (i_out_valid && i_out_ready && !i_out_latch) |-> !i_in_ready, "command taken during a scan")
    // reset clear pass: nothing taken or shown right after reset
    `LMD_ASSERT(a_reset_clear, $rose(i_rst_n) |-> (!i_in_ready && !i_out_valid), "activity during reset clear")

endmodule

bind led_matrix_double_buffer_scanout_unit lmd_checker u_lmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_line  (o_pix.line_address),
    .i_out_bits  ({o_pix.upper_red, o_pix.upper_green, o_pix.upper_blue,
                   o_pix.lower_red, o_pix.lower_green, o_pix.lower_blue}),
    .i_out_latch (o_pix.latch_now)
);

`default_nettype wire
